[sv/orf_pkg.sv]
// ----------------------------------------------------------------------------
// orf_pkg
// Shared types, letter codes and the standard genetic code table for the
// open reading frame translator.
// ----------------------------------------------------------------------------
package orf_pkg;

	localparam int LENGTH_BITS_DEF = 16;
	localparam int OUT_LEN_W       = 16;

	localparam logic [2:0] BASE_A = 3'd0;
	localparam logic [2:0] BASE_C = 3'd1;
	localparam logic [2:0] BASE_G = 3'd2;
	localparam logic [2:0] BASE_T = 3'd3;

	localparam logic [4:0] AA_F    = 5'd0;
	localparam logic [4:0] AA_L    = 5'd1;
	localparam logic [4:0] AA_I    = 5'd2;
	localparam logic [4:0] AA_M    = 5'd3;
	localparam logic [4:0] AA_V    = 5'd4;
	localparam logic [4:0] AA_S    = 5'd5;
	localparam logic [4:0] AA_P    = 5'd6;
	localparam logic [4:0] AA_T    = 5'd7;
	localparam logic [4:0] AA_A    = 5'd8;
	localparam logic [4:0] AA_Y    = 5'd9;
	localparam logic [4:0] AA_H    = 5'd10;
	localparam logic [4:0] AA_Q    = 5'd11;
	localparam logic [4:0] AA_N    = 5'd12;
	localparam logic [4:0] AA_K    = 5'd13;
	localparam logic [4:0] AA_D    = 5'd14;
	localparam logic [4:0] AA_E    = 5'd15;
	localparam logic [4:0] AA_C    = 5'd16;
	localparam logic [4:0] AA_W    = 5'd17;
	localparam logic [4:0] AA_R    = 5'd18;
	localparam logic [4:0] AA_G    = 5'd19;
	localparam logic [4:0] AA_STOP = 5'd20;

	typedef struct packed {
		logic [2:0] first_base;
		logic [2:0] second_base;
		logic [2:0] third_base;
		logic       new_frame;
		logic [2:0] frame_tag;
	} codon_t;

	typedef struct packed {
		logic                 letter_valid;
		logic [4:0]           letter_code;
		logic                 frame_closed;
		logic [OUT_LEN_W-1:0] closed_length;
		logic [OUT_LEN_W-1:0] best_length;
		logic [OUT_LEN_W-1:0] best_end_index;
		logic [2:0]           best_frame_tag;
	} result_t;

	// index is {first, second, third}, two bits each, A C G T
	function automatic logic [4:0] codon_lookup(input logic [5:0] idx);
		logic [4:0] aa;
		case (idx[5:2])
			{BASE_A[1:0], BASE_A[1:0]}: aa = idx[0] ? AA_N : AA_K;
			{BASE_A[1:0], BASE_C[1:0]}: aa = AA_T;
			{BASE_A[1:0], BASE_G[1:0]}: aa = idx[0] ? AA_S : AA_R;
			{BASE_A[1:0], BASE_T[1:0]}: aa = (idx[1:0] == BASE_G[1:0]) ? AA_M : AA_I;
			{BASE_C[1:0], BASE_A[1:0]}: aa = idx[0] ? AA_H : AA_Q;
			{BASE_C[1:0], BASE_C[1:0]}: aa = AA_P;
			{BASE_C[1:0], BASE_G[1:0]}: aa = AA_R;
			{BASE_C[1:0], BASE_T[1:0]}: aa = AA_L;
			{BASE_G[1:0], BASE_A[1:0]}: aa = idx[0] ? AA_D : AA_E;
			{BASE_G[1:0], BASE_C[1:0]}: aa = AA_A;
			{BASE_G[1:0], BASE_G[1:0]}: aa = AA_G;
			{BASE_G[1:0], BASE_T[1:0]}: aa = AA_V;
			{BASE_T[1:0], BASE_A[1:0]}: aa = idx[0] ? AA_Y : AA_STOP;
			{BASE_T[1:0], BASE_C[1:0]}: aa = AA_S;
			{BASE_T[1:0], BASE_G[1:0]}: begin
				case (idx[1:0])
					BASE_A[1:0]: aa = AA_STOP;
					BASE_G[1:0]: aa = AA_W;
					default:     aa = AA_C;
				endcase
			end
			default:                    aa = idx[0] ? AA_F : AA_L;
		endcase
		return aa;
	endfunction

endpackage

[sv/orf_frame_tracker.sv]
// ----------------------------------------------------------------------------
// orf_frame_tracker
// Frame state and best-frame record; forms the result of the codon held in
// the input stage and updates the state when that codon moves on.
// ----------------------------------------------------------------------------
module orf_frame_tracker import orf_pkg::*; #(
	parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    step,
	input  codon_t  codon,
	output result_t result
);

	localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

	logic                   frame_open_q;
	logic [LENGTH_BITS-1:0] run_len_q;
	logic [LENGTH_BITS-1:0] codon_idx_q;
	logic [LENGTH_BITS-1:0] best_len_q;
	logic [LENGTH_BITS-1:0] best_end_q;
	logic [2:0]             best_tag_q;

	logic                   open_now;
	logic [LENGTH_BITS-1:0] run_now;
	logic [LENGTH_BITS-1:0] idx_now;
	logic                   known;
	logic [4:0]             aa;
	logic                   is_stop;
	logic                   opening;
	logic                   closing;
	logic                   emitting;
	logic [LENGTH_BITS-1:0] run_inc;
	logic [LENGTH_BITS-1:0] idx_inc;
	logic                   better;
	logic                   open_nxt;
	logic [LENGTH_BITS-1:0] run_nxt;
	logic [LENGTH_BITS-1:0] best_len_nxt;
	logic [LENGTH_BITS-1:0] best_end_nxt;
	logic [2:0]             best_tag_nxt;

	logic [LENGTH_BITS+OUT_LEN_W-1:0] closed_ext;
	logic [LENGTH_BITS+OUT_LEN_W-1:0] best_len_ext;
	logic [LENGTH_BITS+OUT_LEN_W-1:0] best_end_ext;

	always_comb begin
		open_now = codon.new_frame ? 1'b0 : frame_open_q;
		run_now  = codon.new_frame ? '0 : run_len_q;
		idx_now  = codon.new_frame ? '0 : codon_idx_q;

		known   = ~codon.first_base[2] & ~codon.second_base[2] & ~codon.third_base[2];
		aa      = codon_lookup({codon.first_base[1:0], codon.second_base[1:0],
			codon.third_base[1:0]});
		is_stop = (aa == AA_STOP);

		opening  = known & ~open_now & (aa == AA_M);
		closing  = known & open_now & is_stop;
		emitting = known & open_now;

		run_inc = (run_now == LEN_MAX) ? LEN_MAX : run_now + 1'b1;
		idx_inc = (idx_now == LEN_MAX) ? LEN_MAX : idx_now + 1'b1;
		better  = closing && (run_inc > best_len_q);

		open_nxt = opening | (open_now & ~closing);
		if (opening || closing) begin
			run_nxt = '0;
		end else if (emitting) begin
			run_nxt = run_inc;
		end else begin
			run_nxt = run_now;
		end

		best_len_nxt = better ? run_inc : best_len_q;
		best_end_nxt = better ? idx_now : best_end_q;
		best_tag_nxt = better ? codon.frame_tag : best_tag_q;

		closed_ext   = {{OUT_LEN_W{1'b0}}, (closing ? run_inc : '0)};
		best_len_ext = {{OUT_LEN_W{1'b0}}, best_len_nxt};
		best_end_ext = {{OUT_LEN_W{1'b0}}, best_end_nxt};

		result.letter_valid   = emitting;
		result.letter_code    = emitting ? aa : '0;
		result.frame_closed   = closing;
		result.closed_length  = closed_ext[OUT_LEN_W-1:0];
		result.best_length    = best_len_ext[OUT_LEN_W-1:0];
		result.best_end_index = best_end_ext[OUT_LEN_W-1:0];
		result.best_frame_tag = best_tag_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_open_q <= 1'b0;
			run_len_q    <= '0;
			codon_idx_q  <= '0;
			best_len_q   <= '0;
			best_end_q   <= '0;
			best_tag_q   <= '0;
		end else if (step) begin
			frame_open_q <= open_nxt;
			run_len_q    <= run_nxt;
			codon_idx_q  <= idx_inc;
			best_len_q   <= best_len_nxt;
			best_end_q   <= best_end_nxt;
			best_tag_q   <= best_tag_nxt;
		end
	end

endmodule

[sv/orf_codon_translator.sv]
// ----------------------------------------------------------------------------
// orf_codon_translator
// Translates a stream of codons under the standard genetic code, one reading
// frame at a time, and keeps the longest closed open reading frame. Each
// codon transaction gives exactly one result transaction. A codon is taken
// every cycle as long as results are taken; a codon passes through the input
// register and then the result register, with the table lookup and length
// compare done combinationally between the two.
// ----------------------------------------------------------------------------
module orf_codon_translator import orf_pkg::*; #(
	parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    codon_valid,
	output logic    codon_ready,
	input  codon_t  codon,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	logic    valid_s1;
	codon_t  codon_s1;
	logic    valid_s2;
	result_t result_s2;
	result_t result_nxt;
	logic    advance;

	assign advance     = valid_s1 & (~valid_s2 | result_ready);
	assign codon_ready = ~valid_s1 | advance;

	orf_frame_tracker #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_tracker (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.codon  (codon_s1),
		.result (result_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (codon_ready) begin
				valid_s1 <= codon_valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (result_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (codon_ready && codon_valid) begin
			codon_s1 <= codon;
		end
		if (advance) begin
			result_s2 <= result_nxt;
		end
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

endmodule
